/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the OFDM symbol modulator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/ofdm64_pkg.sv */
// ----------------------------------------------------------------------------
// ofdm64_pkg
// Types, constants and twiddle lookup shared by the OFDM modulator files.
// ----------------------------------------------------------------------------
package ofdm64_pkg;

   localparam int NUM_TX_DEF    = 2;
   localparam int FFT_SIZE      = 64;
   localparam int USED_CARRIERS = 56;
   localparam int GUARD_LEN     = 16;
   localparam int NUM_RESULTS   = (FFT_SIZE + GUARD_LEN) / 2;
   localparam int HALF_USED     = USED_CARRIERS / 2;
   localparam int GUARD_PAIRS   = GUARD_LEN / 2;
   localparam int TAIL_PAIR     = (FFT_SIZE - GUARD_LEN) / 2;

   // Output scale 1/sqrt(56*streams) in Q0.16
   localparam logic [14:0] SCALE_ONE = 15'd8758;
   localparam logic [14:0] SCALE_TWO = 15'd6193;

   // Register indexes
   localparam logic CSR_NUM_STREAMS = 1'b0;
   localparam logic CSR_ACTIVE_ANT  = 1'b1;

   localparam logic [16:0] QCOS [17] = '{
      17'd32768, 17'd32610, 17'd32138, 17'd31357, 17'd30274, 17'd28899,
      17'd27246, 17'd25330, 17'd23170, 17'd20788, 17'd18205, 17'd15447,
      17'd12540, 17'd9512,  17'd6393,  17'd3212,  17'd0
   };

   typedef struct packed {
      logic signed [15:0] ant0_re;
      logic signed [15:0] ant0_im;
      logic signed [15:0] ant1_re;
      logic signed [15:0] ant1_im;
   } req_type;

   typedef struct packed {
      logic signed [15:0] ant0_re_a;
      logic signed [15:0] ant0_im_a;
      logic signed [15:0] ant0_re_b;
      logic signed [15:0] ant0_im_b;
      logic signed [15:0] ant1_re_a;
      logic signed [15:0] ant1_im_a;
      logic signed [15:0] ant1_re_b;
      logic signed [15:0] ant1_im_b;
      logic               symbol_end;
   } rsp_type;

   // One MAC step handed from the sequencer to every lane
   typedef struct packed {
      logic       valid;
      logic       first;
      logic       last;
      logic [5:0] n;
      logic [5:0] m;
   } ctl_type;

   typedef enum logic [2:0] {
      ST_FILL,
      ST_CALC,
      ST_DRAIN,
      ST_READ,
      ST_SEND
   } state_type;

   // cos(2*pi*m/64) in Q1.15, 1.0 = 32768
   function automatic logic signed [16:0] cos_tw(input logic [5:0] m);
      logic [6:0] mm;
      logic [6:0] idx;
      logic       neg;
      logic [16:0] mag;
      mm = {1'b0, m};
      if (mm <= 7'd16) begin
         idx = mm;
         neg = 1'b0;
      end else if (mm <= 7'd32) begin
         idx = 7'd32 - mm;
         neg = 1'b1;
      end else if (mm <= 7'd48) begin
         idx = mm - 7'd32;
         neg = 1'b1;
      end else begin
         idx = 7'd64 - mm;
         neg = 1'b0;
      end
      mag = QCOS[idx[4:0]];
      return neg ? -signed'(mag) : signed'(mag);
   endfunction

endpackage

/* src/ofdm64_lane.sv */
// ----------------------------------------------------------------------------
// ofdm64_lane
// One antenna lane: bin buffer, complex MAC pipeline, scaling and the
// time-sample buffer split into even and odd banks.
// ----------------------------------------------------------------------------
module ofdm64_lane (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  logic [5:0]          wr_addr,
   input  logic [31:0]         wr_data,
   input  logic [5:0]          mac_addr,
   input  ofdm64_pkg::ctl_type ctl_in,
   input  logic [14:0]         scale,
   input  logic                rd_en,
   input  logic [4:0]          rd_addr,
   output logic [31:0]         rd_even,
   output logic [31:0]         rd_odd
);
   import ofdm64_pkg::*;

   logic [31:0] bin_mem [64];
   logic [31:0] even_mem [32];
   logic [31:0] odd_mem [32];

   logic [31:0] bin_ff;
   ctl_type     ctl1_ff, ctl2_ff, ctl3_ff, ctl4_ff;
   logic signed [32:0] p_rc_ff, p_is_ff, p_rs_ff, p_ic_ff;
   logic signed [39:0] acc_re_ff, acc_im_ff;
   logic signed [54:0] mul_re_ff, mul_im_ff;
   logic [31:0] even_ff, odd_ff;

   logic signed [15:0] xr, xi;
   logic signed [16:0] cw, sw;
   logic signed [33:0] term_re, term_im;
   logic signed [15:0] q_re, q_im;

   function automatic logic signed [15:0] round_sat(input logic signed [54:0] v);
      logic signed [54:0] t;
      logic signed [23:0] q;
      t = v + 55'sd1073741824;
      q = 24'(t >>> 31);
      if (q > 24'sd32767)       return 16'sh7fff;
      else if (q < -24'sd32768) return 16'sh8000;
      else                      return q[15:0];
   endfunction

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bin_mem[wr_addr] <= wr_data;
      end
      bin_ff <= bin_mem[mac_addr];
   end

   assign xr = signed'(bin_ff[31:16]);
   assign xi = signed'(bin_ff[15:0]);
   assign cw = cos_tw(ctl1_ff.m);
   assign sw = cos_tw(ctl1_ff.m + 6'd48);

   always_ff @(posedge clock) begin
      p_rc_ff <= xr * cw;
      p_is_ff <= xi * sw;
      p_rs_ff <= xr * sw;
      p_ic_ff <= xi * cw;
   end

   assign term_re = 34'(p_rc_ff) - 34'(p_is_ff);
   assign term_im = 34'(p_rs_ff) + 34'(p_ic_ff);

   always_ff @(posedge clock) begin
      if (ctl2_ff.valid) begin
         acc_re_ff <= ctl2_ff.first ? 40'(term_re) : acc_re_ff + 40'(term_re);
         acc_im_ff <= ctl2_ff.first ? 40'(term_im) : acc_im_ff + 40'(term_im);
      end
      mul_re_ff <= 55'(acc_re_ff * signed'({1'b0, scale}));
      mul_im_ff <= 55'(acc_im_ff * signed'({1'b0, scale}));
   end

   assign q_re = round_sat(mul_re_ff);
   assign q_im = round_sat(mul_im_ff);

   always_ff @(posedge clock) begin
      if (ctl4_ff.valid && ctl4_ff.last) begin
         if (ctl4_ff.n[0]) odd_mem[ctl4_ff.n[5:1]]  <= {q_re, q_im};
         else              even_mem[ctl4_ff.n[5:1]] <= {q_re, q_im};
      end
      if (rd_en) begin
         even_ff <= even_mem[rd_addr];
         odd_ff  <= odd_mem[rd_addr];
      end
   end

   // Control pipeline follows the data one stage at a time
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
         ctl4_ff <= '0;
      end else begin
         ctl1_ff <= ctl_in;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
         ctl4_ff <= ctl3_ff;
      end
   end

   assign rd_even = even_ff;
   assign rd_odd  = odd_ff;

endmodule

/* src/ofdm_symbol_modulator_64_unit.sv */
// ----------------------------------------------------------------------------
// ofdm_symbol_modulator_64_unit
// Two-antenna 64-point OFDM symbol modulator with 16-sample cyclic prefix.
// ----------------------------------------------------------------------------
// Usage:
//  req channel: one subcarrier beat per antenna pair; 56 beats make a symbol.
//    Subcarriers 0..27 land on bins 1..28, 28..55 on bins 36..63.
//  After the 56th beat req_stall stays high while each antenna lane runs a
//    direct 64 x 56 complex MAC (one MAC per lane per cycle), then drains the pipeline.
//  rsp channel: 40 beats per symbol, two time samples per beat, prefix
//    (samples 48..63) first; symbol_end marks the 40th. Each beat is a buffer
//    read, then present; the next is read only after it is taken (rsp_stall low).
//  The single MAC in each lane sets the symbol throughput; a new symbol is
//    taken only after the last beat of the previous one has been sent.
//  rsp_stall simply holds the current beat; nothing is lost.
//  csr port: index 0 num_streams, index 1 active_antennas; values are
//    sampled on the 56th beat. Antenna 1 outputs zero unless active_antennas >= 2.
//  Reset (synchronous) clears the subcarrier count and loads num_streams 1,
//    active_antennas 2.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ofdm_symbol_modulator_64_unit #(
   parameter int NUM_TX = ofdm64_pkg::NUM_TX_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  ofdm64_pkg::req_type req,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output ofdm64_pkg::rsp_type rsp,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [1:0]          csr_wdata
);
   import ofdm64_pkg::*;

   state_type   state_ff, state_in;
   logic [5:0]  cnt_ff, cnt_in;        // subcarrier index (fill and MAC)
   logic [5:0]  n_ff, n_in;            // time sample under computation
   logic [2:0]  drain_ff, drain_in;
   logic [5:0]  r_ff, r_in;            // result beat index
   logic [1:0]  streams_ff, ants_ff;
   logic [14:0] scale_ff;
   logic        ant1_on_ff;

   logic        req_fire, rsp_fire, last_sub, rd_en;
   logic [5:0]  bin;
   logic [4:0]  rd_addr;
   ctl_type     ctl;
   logic [31:0] even_q [2];
   logic [31:0] odd_q [2];
   logic [31:0] ant1_even, ant1_odd;

   assign req_fire = req_valid && !req_stall;
   assign rsp_fire = rsp_valid && !rsp_stall;
   assign last_sub = (cnt_ff == 6'(USED_CARRIERS - 1));

   // ---- configuration registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         streams_ff <= 2'd1;
         ants_ff    <= 2'd2;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NUM_STREAMS: streams_ff <= csr_wdata;
            CSR_ACTIVE_ANT:  ants_ff    <= csr_wdata;
            default:         ;
         endcase
      end
   end

   // Settings captured on the symbol's last subcarrier
   always_ff @(posedge clock) begin
      if (reset) begin
         ant1_on_ff <= 1'b0;
      end else if (req_fire && last_sub) begin
         ant1_on_ff <= (ants_ff >= 2'd2) && (NUM_TX >= 2);
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && last_sub) begin
         scale_ff <= (streams_ff >= 2'd2) ? SCALE_TWO : SCALE_ONE;
      end
   end

   // ---- sequencer ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
         cnt_ff   <= '0;
         n_ff     <= '0;
         drain_ff <= '0;
         r_ff     <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         n_ff     <= n_in;
         drain_ff <= drain_in;
         r_ff     <= r_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      n_in      = n_ff;
      drain_in  = drain_ff;
      r_in      = r_ff;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      rd_en     = 1'b0;
      ctl       = '0;
      unique case (state_ff)
         ST_FILL: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (last_sub) begin
                  cnt_in   = '0;
                  n_in     = '0;
                  state_in = ST_CALC;
               end else begin
                  cnt_in = cnt_ff + 6'd1;
               end
            end
         end
         ST_CALC: begin
            ctl.valid = 1'b1;
            ctl.first = (cnt_ff == 6'd0);
            ctl.last  = last_sub;
            ctl.n     = n_ff;
            ctl.m     = 6'(bin * n_ff);
            if (last_sub) begin
               cnt_in = '0;
               n_in   = n_ff + 6'd1;
               if (n_ff == 6'(FFT_SIZE - 1)) begin
                  drain_in = '0;
                  state_in = ST_DRAIN;
               end
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         ST_DRAIN: begin
            drain_in = drain_ff + 3'd1;
            if (drain_ff == 3'd5) begin
               r_in     = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_SEND;
         end
         ST_SEND: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (r_ff == 6'(NUM_RESULTS - 1)) begin
                  state_in = ST_FILL;
               end else begin
                  r_in     = r_ff + 6'd1;
                  state_in = ST_READ;
               end
            end
         end
         default: state_in = ST_FILL;
      endcase
   end

   // Subcarrier to bin: skip DC and the guard bins 29..35
   assign bin = (cnt_ff < 6'(HALF_USED)) ? cnt_ff + 6'd1
                                         : cnt_ff + 6'(FFT_SIZE - USED_CARRIERS);

   // Sample pairs: prefix beats read the tail of the symbol
   assign rd_addr = (r_ff < 6'(GUARD_PAIRS)) ? 5'(r_ff + 6'(TAIL_PAIR))
                                            : 5'(r_ff - 6'(GUARD_PAIRS));

   // ---- antenna lanes ----
   for (genvar g = 0; g < 2; g++) begin : g_lane
      if (g < NUM_TX) begin : g_on
         ofdm64_lane u_lane (
            .clock    (clock),
            .reset    (reset),
            .wr_en    (req_fire),
            .wr_addr  (cnt_ff),
            .wr_data  ((g == 0) ? {req.ant0_re, req.ant0_im}
                                : {req.ant1_re, req.ant1_im}),
            .mac_addr (cnt_ff),
            .ctl_in   (ctl),
            .scale    (scale_ff),
            .rd_en    (rd_en),
            .rd_addr  (rd_addr),
            .rd_even  (even_q[g]),
            .rd_odd   (odd_q[g])
         );
      end else begin : g_off
         assign even_q[g] = '0;
         assign odd_q[g]  = '0;
      end
   end

   // ---- merge lanes into the result beat ----
   assign ant1_even = ant1_on_ff ? even_q[1] : '0;
   assign ant1_odd  = ant1_on_ff ? odd_q[1]  : '0;

   always_comb begin
      rsp.ant0_re_a  = even_q[0][31:16];
      rsp.ant0_im_a  = even_q[0][15:0];
      rsp.ant0_re_b  = odd_q[0][31:16];
      rsp.ant0_im_b  = odd_q[0][15:0];
      rsp.ant1_re_a  = ant1_even[31:16];
      rsp.ant1_im_a  = ant1_even[15:0];
      rsp.ant1_re_b  = ant1_odd[31:16];
      rsp.ant1_im_b  = ant1_odd[15:0];
      rsp.symbol_end = (r_ff == 6'(NUM_RESULTS - 1));
   end

   // ---- checks ----
   `ASSERT_IMPL(a_no_req_while_rsp, clock, reset, rsp_valid, req_stall, "req during output")
   `ASSERT_NEXT(a_fill_after_end, clock, reset, rsp_fire && rsp.symbol_end, !req_stall, "no fill")
   `ASSERT_NEXT(a_calc_after_last, clock, reset, req_fire && last_sub, state_ff == ST_CALC, "no calc")
   `ASSERT_NEXT(a_gap_between_beats, clock, reset, rsp_fire && !rsp.symbol_end, !rsp_valid, "no gap")

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the OFDM symbol modulator. Subcarrier beats are
// driven through the request channel. A local inverse-DFT model predicts the 40
// time-domain beats of every symbol, and each response is compared with the
// expected beat as a whole. Idle gaps are random on both channels but in the last phase.
// ----------------------------------------------------------------------------
module testbench;
   import ofdm64_pkg::*;

   localparam int  MAX_CYCLES = 200000;
   localparam int  DRAIN_WAIT = 200;
   localparam int  NUM_ROWS   = 3;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp;
   logic    csr_we;
   logic    csr_index;
   logic [1:0] csr_wdata;

   ofdm_symbol_modulator_64_unit dut (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Predictor state: stored bins per antenna, beat count, register copies
   logic signed [15:0] bin_re [2][64];
   logic signed [15:0] bin_im [2][64];
   int          sc_count;
   logic [1:0]  streams_q;
   logic [1:0]  antennas_q;
   rsp_type     sample_beats [$];
   rsp_type     typed_beat;
   int          errors;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          hold_cycles;
   longint      cycle_count;

   // Quarter-wave cosine, 1.0 = 32768
   function automatic int qcos(int m);
      int t [17] = '{32768, 32610, 32138, 31357, 30274, 28899, 27246, 25330,
                     23170, 20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};
      m = m & 63;
      if (m <= 16) return t[m];
      if (m <= 32) return -t[32 - m];
      if (m <= 48) return -t[m - 32];
      return t[64 - m];
   endfunction

   function automatic logic signed [15:0] scale_sat(longint acc, longint s);
      longint v;
      longint q;
      v = acc * s;
      if (v >= 0) q = (v + (64'sd1 <<< 30)) >>> 31;
      else        q = -((-v + (64'sd1 <<< 30) - 1) >>> 31);
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
   endfunction

   // Store one beat; on the 56th, compute the symbol and queue 40 beats
   task automatic model_subcarrier(input req_type b);
      logic signed [15:0] tr [2][64];
      logic signed [15:0] ti [2][64];
      int     bin;
      int     nact;
      longint s;
      longint ar;
      longint ai;
      int     t;
      rsp_type o;
      bin = (sc_count < HALF_USED) ? sc_count + 1 : sc_count + 8;
      bin_re[0][bin] = b.ant0_re;
      bin_im[0][bin] = b.ant0_im;
      bin_re[1][bin] = b.ant1_re;
      bin_im[1][bin] = b.ant1_im;
      sc_count++;
      if (sc_count < USED_CARRIERS) return;
      sc_count = 0;
      s    = (streams_q >= 2) ? 6193 : 8758;
      nact = (antennas_q >= 2) ? 2 : 1;
      for (int a = 0; a < 2; a++)
         for (int n = 0; n < 64; n++) begin
            ar = 0;
            ai = 0;
            if (a < nact)
               for (int k = 1; k < 64; k++) begin
                  if (k > 28 && k < 36) continue;
                  ar += longint'(bin_re[a][k]) * qcos(k * n)
                      - longint'(bin_im[a][k]) * qcos(k * n + 48);
                  ai += longint'(bin_re[a][k]) * qcos(k * n + 48)
                      + longint'(bin_im[a][k]) * qcos(k * n);
               end
            tr[a][n] = scale_sat(ar, s);
            ti[a][n] = scale_sat(ai, s);
         end
      for (int r = 0; r < NUM_RESULTS; r++) begin
         t = (2 * r < GUARD_LEN) ? 2 * r + 48 : 2 * r - GUARD_LEN;
         o.ant0_re_a = tr[0][t];     o.ant0_im_a = ti[0][t];
         o.ant0_re_b = tr[0][t + 1]; o.ant0_im_b = ti[0][t + 1];
         o.ant1_re_a = tr[1][t];     o.ant1_im_a = ti[1][t];
         o.ant1_re_b = tr[1][t + 1]; o.ant1_im_b = ti[1][t + 1];
         o.symbol_end = (r == NUM_RESULTS - 1);
         sample_beats.push_back(o);
      end
   endtask

   // Directed rows: field extremes, a single tone and an all-zero symbol
   typedef enum logic [1:0] {PAT_EXTREME, PAT_TONE, PAT_ZERO, PAT_RAND} pattern_type;

   // One directed symbol: settings, receiver hold-off, typed zero result
   typedef struct {
      pattern_type pat;
      logic        cfg;
      logic [1:0]  streams;
      logic [1:0]  ants;
      int          hold;
      logic        zero_out;
      logic        settle;
   } row_type;

   row_type rows [NUM_ROWS] = '{
      '{PAT_EXTREME, 1'b0, 2'd1, 2'd2, 0,    1'b0, 1'b0},
      '{PAT_TONE,    1'b0, 2'd1, 2'd2, 5000, 1'b0, 1'b1},
      '{PAT_ZERO,    1'b1, 2'd3, 2'd0, 0,    1'b1, 1'b1}
   };

   function automatic req_type make_beat(pattern_type p, int i);
      req_type b;
      case (p)
         PAT_EXTREME: begin
            b = (i % 2) ? {16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF}
                        : {16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000};
         end
         PAT_TONE: begin
            b = '0;
            if (i == 3) b = {16'sh7FFF, 16'sh0000, 16'sh0000, 16'sh8000};
         end
         PAT_ZERO: b = '0;
         default: b = {$urandom, $urandom};
      endcase
      return b;
   endfunction

   task automatic csr_write(input logic idx, input logic [1:0] v);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_NUM_STREAMS) streams_q = v;
      else                        antennas_q = v;
   endtask

   task automatic send_beat(input req_type b);
      while ($urandom_range(99) < send_idle_pct) begin
         @(posedge clock);
         req_valid <= 1'b0;
      end
      @(posedge clock);
      req_valid <= 1'b1;
      req       <= b;
      do @(posedge clock); while (req_stall);
      model_subcarrier(b);
      req_valid <= 1'b0;
   endtask

   task automatic send_symbol(input pattern_type p);
      for (int i = 0; i < USED_CARRIERS; i++) send_beat(make_beat(p, i));
   endtask

   task automatic wait_idle();
      while (sample_beats.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // Response checker
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (sample_beats.size() == 0) begin
            $display("%0t: unexpected beat %h", $time, rsp);
            errors++;
         end else begin
            e = sample_beats.pop_front();
            if (rsp !== e) begin
               $display("%0t: mismatch expected %h actual %h", $time, e, rsp);
               errors++;
            end
         end
      end
   end

   // Receiver stall generator; hold_cycles forces a long hold-off
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall   <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLES) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      req_valid = 1'b0; req = '0; csr_we = 1'b0; csr_index = 1'b0; csr_wdata = '0;
      rsp_stall = 1'b0; hold_cycles = 0; cycle_count = 0; errors = 0;
      send_idle_pct = 26; recv_idle_pct = 77;
      sc_count = 0; streams_q = 2'd1; antennas_q = 2'd2;
      typed_beat = '0;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed rows; the tone row sets a long receiver hold-off, the zero row
      // expects all-zero samples
      for (int i = 0; i < NUM_ROWS; i++) begin
         if (rows[i].cfg) begin
            csr_write(CSR_NUM_STREAMS, rows[i].streams);
            csr_write(CSR_ACTIVE_ANT, rows[i].ants);
         end
         if (rows[i].hold > 0) hold_cycles = rows[i].hold;
         send_symbol(rows[i].pat);
         if (rows[i].zero_out) begin
            sample_beats.delete();
            for (int r = 0; r < NUM_RESULTS; r++) begin
               typed_beat = '0;
               typed_beat.symbol_end = (r == NUM_RESULTS - 1);
               sample_beats.push_back(typed_beat);
            end
         end
         if (rows[i].settle) wait_idle();
      end

      // Random part across the remaining idling phases and settings
      for (int ph = 1; ph < 3; ph++) begin
         if (ph == 1) begin send_idle_pct = 77; recv_idle_pct = 26; end
         if (ph == 2) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
         csr_write(CSR_NUM_STREAMS, 2'($urandom_range(0, 3)));
         csr_write(CSR_ACTIVE_ANT, 2'($urandom_range(0, 3)));
         send_symbol(PAT_RAND);
         wait_idle();
      end

      while (sample_beats.size() != 0 && cycle_count < MAX_CYCLES) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0 && sample_beats.size() == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule

/* files.f */
+incdir+src
src/ofdm64_pkg.sv
src/ofdm64_lane.sv
src/ofdm_symbol_modulator_64_unit.sv
dv/testbench.sv
